// File: rtl/trail_point_buffer_arc_sampler_core_defines.svh
// Assertion macros for the trail point buffer arc sampler
`ifndef TRAIL_POINT_BUFFER_ARC_SAMPLER_CORE_DEFINES_SVH
`define TRAIL_POINT_BUFFER_ARC_SAMPLER_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TPB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tpbas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbas_pkg
// Types and constants shared by the trail point buffer arc sampler.
// ----------------------------------------------------------------------------
package tpbas_pkg;

    localparam int MAX_POINTS = 64;
    localparam int SLOT_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_SAMPLE = 2'd2
    } t_cmd;

    localparam logic CFG_MIN_SEG = 1'b0;
    localparam logic CFG_LIFE    = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_RD,     // read newest point
        ST_DIST_MUL,   // square one axis per cycle
        ST_ADD_DEC,    // compare and store
        ST_TICK_RD,    // read age
        ST_TICK_WR,    // write saturated age
        ST_TRIM_RD,    // read oldest age
        ST_TRIM_CHK,
        ST_SEG_RDA,    // read segment start
        ST_SEG_RDB,    // read segment end
        ST_SEG_MUL,
        ST_SQRT,       // one root bit per cycle
        ST_SEG_DONE,
        ST_TGT_MUL,
        ST_DIV,        // one quotient bit per cycle
        ST_LERP_MUL,   // one axis per cycle
        ST_LAST_RD,
        ST_LAST_LD,
        ST_OUT
    } t_state;

endpackage

// File: rtl/trail_point_buffer_arc_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trail_point_buffer_arc_sampler_core
// Ring of 3D trail points with ageing and arc-length sampling.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (cmd, position, tick amount, fraction) arrive on a valid/ready
//   channel; each gives exactly one result word on the output channel.
//   Configuration (minimum segment distance, lifetime) is written through a
//   plain write port; write it only while the block is idle (the block does
//   not enforce this). Add reads the newest point, squares the differences
//   and compares before storing; tick reads and writes each stored age, then
//   trims expired oldest points; sample walks the segments twice, the second
//   time up to the target, each segment two reads, three squares and a
//   33-step root, one bit per cycle, then a 51-step divide (skipped for a
//   zero-length segment) and three interpolation multiplies. The multiplier
//   is shared, the root/divide unit is bit-serial and the memory single-port.
//   One word is in work at a time; ready is low meanwhile.
//   Reset clears count, oldest slot, minimum segment and handshake state and
//   sets lifetime to 65536; the point memory is not cleared (only entries
//   within the count are read). If the receiver stalls, the result is held in
//   the output register and no new word is taken until it is delivered.
// ----------------------------------------------------------------------------
`include "trail_point_buffer_arc_sampler_core_defines.svh"

module trail_point_buffer_arc_sampler_core
    import tpbas_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0]        i_tick_amount,
    input  logic [16:0]        i_sample_fraction,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [6:0]         o_points_held,
    output logic               o_accepted,
    output logic               o_dropped_oldest
);

    // point memories, single port, registered read
    logic [31:0] m_x   [MAX_POINTS];
    logic [31:0] m_y   [MAX_POINTS];
    logic [31:0] m_z   [MAX_POINTS];
    logic [31:0] m_age [MAX_POINTS];

    t_state r_state, n_state;

    logic [31:0]       r_min_seg, r_life;
    logic [SLOT_W-1:0] r_oldest;
    logic [CNT_W-1:0]  r_count;

    // latched input word
    logic [31:0] r_px, r_py, r_pz, r_dt;
    logic [16:0] r_u;

    // memory port
    logic              mem_we_pos, mem_we_age;
    logic [SLOT_W-1:0] mem_addr;
    logic [31:0]       mem_wx, mem_wy, mem_wz, mem_wage;
    logic [31:0]       r_rx, r_ry, r_rz, r_rage;

    // working registers
    logic [CNT_W-1:0]  r_idx;
    logic [31:0]       r_ax, r_ay, r_az;      // segment start
    logic [32:0]       r_dx, r_dy, r_dz;      // signed differences
    logic [1:0]        r_axis;
    logic [65:0]       r_sum;                 // squared distance
    logic [5:0]        r_step;
    logic [33:0]       r_root;
    logic [35:0]       r_rem;
    logic [39:0]       r_total, r_accum, r_target;
    logic [33:0]       r_len;
    logic              r_pass2;
    logic [50:0]       r_num;                 // dividend (target-accum)<<16
    logic [33:0]       r_quo;
    logic [34:0]       r_drem;

    // output register
    logic        r_ovalid;
    logic [31:0] r_ox, r_oy, r_oz;
    logic        r_oacc, r_odrop;

    // shared multiplier operands (unsigned 33x33)
    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    function automatic logic [32:0] f_mag(input logic [32:0] d);
        return d[32] ? (~d + 33'd1) : d;
    endfunction

    function automatic logic [32:0] f_diff(input logic [31:0] b, input logic [31:0] a);
        return {b[31], b} - {a[31], a};
    endfunction

    // squaring runs on axis steps 1..3, interpolation on 0..2
    logic [1:0]  d_sel;
    logic [32:0] cur_d;
    assign d_sel = (r_state == ST_LERP_MUL) ? r_axis : r_axis - 2'd1;
    always_comb begin
        unique case (d_sel)
            2'd0:    cur_d = r_dx;
            2'd1:    cur_d = r_dy;
            default: cur_d = r_dz;
        endcase
    end

    logic [SLOT_W-1:0] slot_idx;
    assign slot_idx = r_oldest + r_idx[SLOT_W-1:0];

    // sqrt step
    logic [35:0] sq_rem_sh, sq_trial;
    logic [1:0]  sq_pair;
    assign sq_pair   = r_sum[65:64];
    assign sq_rem_sh = {r_rem[33:0], sq_pair};
    assign sq_trial  = {r_root[33:0], 2'b01};

    // divide step
    logic [34:0] dv_sh;
    assign dv_sh = {r_drem[33:0], r_num[50]};

    logic [16:0] u_cl;
    assign u_cl = (r_u > 17'd65536) ? 17'd65536 : r_u;

    logic [33:0] lerp_off;
    assign lerp_off = mul_p[49:16];

    logic [39:0] seg_end;
    assign seg_end = r_accum + {6'd0, r_root};

    // target product: low 20 bits of total, then high 20 bits shifted in
    logic [65:0] tgt_sum;
    assign tgt_sum = r_sum + {mul_p[45:0], 20'd0};

    logic [63:0] msq;
    assign msq = {32'd0, r_min_seg} * {32'd0, r_min_seg};

    logic [32:0] age_sum;
    assign age_sum = {1'b0, r_rage} + {1'b0, r_dt};

    logic in_fire, out_fire;
    assign o_ready  = (r_state == ST_IDLE) && !r_ovalid;
    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_ovalid && i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    priority if (i_cmd == CMD_ADD) begin
                        n_state = (r_count == '0) ? ST_ADD_DEC : ST_ADD_RD;
                    end else if (i_cmd == CMD_TICK) begin
                        n_state = (r_count == '0) ? ST_OUT : ST_TICK_RD;
                    end else if (i_cmd == CMD_SAMPLE && r_count != '0) begin
                        n_state = (r_count == CNT_W'(1)) ? ST_LAST_RD : ST_SEG_RDA;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_ADD_RD:   n_state = ST_DIST_MUL;
            ST_DIST_MUL: if (r_axis == 2'd3) n_state = ST_ADD_DEC;
            ST_ADD_DEC:  n_state = ST_OUT;
            ST_TICK_RD:  n_state = ST_TICK_WR;
            ST_TICK_WR:  n_state = (r_idx + CNT_W'(1) == r_count) ? ST_TRIM_RD : ST_TICK_RD;
            ST_TRIM_RD:  n_state = (r_count == '0) ? ST_OUT : ST_TRIM_CHK;
            ST_TRIM_CHK: n_state = (r_rage > r_life) ? ST_TRIM_RD : ST_OUT;
            ST_SEG_RDA:  n_state = ST_SEG_RDB;
            ST_SEG_RDB:  n_state = ST_SEG_MUL;
            ST_SEG_MUL:  if (r_axis == 2'd3) n_state = ST_SQRT;
            ST_SQRT:     if (r_step == 6'd32) n_state = ST_SEG_DONE;
            ST_SEG_DONE: begin
                if (!r_pass2) begin
                    n_state = (r_idx + CNT_W'(2) == r_count) ? ST_TGT_MUL : ST_SEG_RDA;
                end else if (r_target <= seg_end) begin
                    n_state = (r_root == '0) ? ST_LERP_MUL : ST_DIV;
                end else begin
                    n_state = (r_idx + CNT_W'(2) == r_count) ? ST_LAST_RD : ST_SEG_RDA;
                end
            end
            ST_TGT_MUL: begin
                if (r_axis == 2'd1) n_state = (r_total == '0) ? ST_LAST_RD : ST_SEG_RDA;
            end
            ST_DIV:      if (r_step == 6'd50) n_state = ST_LERP_MUL;
            ST_LERP_MUL: if (r_axis == 2'd2) n_state = ST_OUT;
            ST_LAST_RD:  n_state = ST_LAST_LD;
            ST_LAST_LD:  n_state = ST_OUT;
            ST_OUT:      n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // memory port and multiplier operands
    always_comb begin
        mem_we_pos = 1'b0;
        mem_we_age = 1'b0;
        mem_addr   = slot_idx;
        mem_wx     = r_px;
        mem_wy     = r_py;
        mem_wz     = r_pz;
        mem_wage   = '0;
        mul_a      = f_mag(cur_d);
        mul_b      = f_mag(cur_d);
        unique case (r_state)
            ST_ADD_RD:  mem_addr = r_oldest + SLOT_W'(r_count - CNT_W'(1));
            ST_ADD_DEC: begin
                mem_addr = (r_count == CNT_W'(MAX_POINTS)) ? r_oldest
                                                          : r_oldest + r_count[SLOT_W-1:0];
                if (r_count == '0 || r_sum[65:64] != 2'd0 || r_sum[63:0] >= msq) begin
                    mem_we_pos = 1'b1;
                    mem_we_age = 1'b1;
                end
            end
            ST_TICK_WR: begin
                mem_we_age = 1'b1;
                mem_wage   = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
            end
            ST_TRIM_RD: mem_addr = r_oldest;
            ST_SEG_RDA: mem_addr = slot_idx;
            ST_SEG_RDB: mem_addr = slot_idx + SLOT_W'(1);
            ST_TGT_MUL: begin
                mul_a = (r_axis == 2'd0) ? {13'd0, r_total[19:0]} : {13'd0, r_total[39:20]};
                mul_b = {16'd0, u_cl};
            end
            ST_LERP_MUL: mul_b = {16'd0, r_quo[16:0]};
            ST_LAST_RD: mem_addr = r_oldest + SLOT_W'(r_count - CNT_W'(1));
            default: ;
        endcase
    end

    // point memories
    always_ff @(posedge i_clk) begin
        if (mem_we_pos) begin
            m_x[mem_addr] <= mem_wx;
            m_y[mem_addr] <= mem_wy;
            m_z[mem_addr] <= mem_wz;
        end
        if (mem_we_age) begin
            m_age[mem_addr] <= mem_wage;
        end
        r_rx   <= m_x[mem_addr];
        r_ry   <= m_y[mem_addr];
        r_rz   <= m_z[mem_addr];
        r_rage <= m_age[mem_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_min_seg <= '0;
            r_life   <= 32'd65536;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_SEG: r_min_seg <= i_cfg_data;
                    CFG_LIFE:    r_life    <= i_cfg_data;
                endcase
            end
            if (out_fire) r_ovalid <= 1'b0;
            if (r_state == ST_OUT) r_ovalid <= 1'b1;
            if (r_state == ST_ADD_DEC && mem_we_pos) begin
                if (r_count == CNT_W'(MAX_POINTS)) r_oldest <= r_oldest + SLOT_W'(1);
                else r_count <= r_count + CNT_W'(1);
            end
            if (r_state == ST_TRIM_CHK && r_rage > r_life) begin
                r_oldest <= r_oldest + SLOT_W'(1);
                r_count  <= r_count - CNT_W'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_px    <= i_pos_x;
                    r_py    <= i_pos_y;
                    r_pz    <= i_pos_z;
                    r_dt    <= i_tick_amount;
                    r_u     <= i_sample_fraction;
                    r_idx   <= '0;
                    r_axis  <= '0;
                    r_sum   <= '0;
                    r_total <= '0;
                    r_accum <= '0;
                    r_pass2 <= 1'b0;
                    r_ox    <= '0;
                    r_oy    <= '0;
                    r_oz    <= '0;
                    r_oacc  <= (i_cmd == CMD_TICK);
                    r_odrop <= 1'b0;
                end
            end
            ST_ADD_RD: r_axis <= 2'd0;
            ST_DIST_MUL: begin
                if (r_axis == 2'd0) begin
                    r_dx <= f_diff(r_px, r_rx);
                    r_dy <= f_diff(r_py, r_ry);
                    r_dz <= f_diff(r_pz, r_rz);
                    r_axis <= 2'd1;
                end else begin
                    r_sum  <= r_sum + mul_p;
                    r_axis <= r_axis + 2'd1;
                end
            end
            ST_ADD_DEC: begin
                if (mem_we_pos) begin
                    r_oacc  <= 1'b1;
                    r_odrop <= (r_count == CNT_W'(MAX_POINTS));
                end
            end
            ST_TICK_WR: r_idx <= r_idx + CNT_W'(1);
            ST_SEG_RDB: begin
                r_ax <= r_rx;
                r_ay <= r_ry;
                r_az <= r_rz;
            end
            ST_SEG_MUL: begin
                if (r_axis == 2'd0) begin
                    r_dx <= f_diff(r_rx, r_ax);
                    r_dy <= f_diff(r_ry, r_ay);
                    r_dz <= f_diff(r_rz, r_az);
                    r_sum <= '0;
                    r_axis <= 2'd1;
                end else begin
                    r_sum  <= r_sum + mul_p;
                    r_axis <= r_axis + 2'd1;
                end
                r_step <= '0;
                r_root <= '0;
                r_rem  <= '0;
            end
            ST_SQRT: begin
                if (sq_rem_sh >= sq_trial) begin
                    r_rem  <= sq_rem_sh - sq_trial;
                    r_root <= {r_root[32:0], 1'b1};
                end else begin
                    r_rem  <= sq_rem_sh;
                    r_root <= {r_root[32:0], 1'b0};
                end
                r_sum  <= {r_sum[63:0], 2'b00};
                r_step <= r_step + 6'd1;
            end
            ST_SEG_DONE: begin
                r_axis <= '0;
                r_len  <= r_root;
                if (!r_pass2) begin
                    r_total <= r_total + {6'd0, r_root};
                    r_idx   <= r_idx + CNT_W'(1);
                end else if (r_target <= seg_end) begin
                    r_num  <= {r_target[34:0] - r_accum[34:0], 16'd0};
                    r_drem <= '0;
                    r_quo  <= '0;
                    r_step <= '0;
                end else begin
                    r_accum <= seg_end;
                    r_idx   <= r_idx + CNT_W'(1);
                end
            end
            ST_TGT_MUL: begin
                if (r_axis == 2'd0) begin
                    r_sum  <= mul_p;
                    r_axis <= 2'd1;
                end else begin
                    r_target <= tgt_sum[55:16];
                    r_pass2  <= 1'b1;
                    r_idx    <= '0;
                    r_axis   <= '0;
                end
            end
            ST_DIV: begin
                if (dv_sh >= {1'b0, r_len}) begin
                    r_drem <= dv_sh - {1'b0, r_len};
                    r_quo  <= {r_quo[32:0], 1'b1};
                end else begin
                    r_drem <= dv_sh;
                    r_quo  <= {r_quo[32:0], 1'b0};
                end
                r_num  <= {r_num[49:0], 1'b0};
                r_step <= r_step + 6'd1;
            end
            ST_LERP_MUL: begin
                unique case (r_axis)
                    2'd0: r_ox <= cur_d[32] ? r_ax - lerp_off[31:0] : r_ax + lerp_off[31:0];
                    2'd1: r_oy <= cur_d[32] ? r_ay - lerp_off[31:0] : r_ay + lerp_off[31:0];
                    default: r_oz <= cur_d[32] ? r_az - lerp_off[31:0]
                                               : r_az + lerp_off[31:0];
                endcase
                r_axis <= r_axis + 2'd1;
                r_oacc <= 1'b1;
            end
            ST_LAST_LD: begin
                r_ox   <= r_rx;
                r_oy   <= r_ry;
                r_oz   <= r_rz;
                r_oacc <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid          = r_ovalid;
    assign o_out_x          = r_ox;
    assign o_out_y          = r_oy;
    assign o_out_z          = r_oz;
    assign o_points_held    = 7'(r_count);
    assign o_accepted       = r_oacc;
    assign o_dropped_oldest = r_odrop;

    // checks
    `TPB_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_POINTS),
                    "point count beyond capacity")
    `TPB_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != ST_IDLE, !o_ready,
                    "ready while a word is in work")
    `TPB_ASSERT_NEXT(a_out_follows, i_clk, i_rst_n, r_state == ST_OUT, o_valid,
                     "result not presented after completion")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail point buffer arc sampler testbench
// Drives add, tick, sample and undefined command words through the valid/ready
// channels with random gaps and stalls. A behavioural model of the point ring
// predicts each result word (typed directed rows carry their own expected
// word), which is compared field by field. Several lifetime and minimum
// distance settings are visited. A directed table runs first.
module tb;
    import tpbas_pkg::*;

    localparam int RING       = MAX_POINTS;
    localparam int WATCH_MAX  = 40000;
    localparam int PHASE_LEN  = 80;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [6:0]         held;
        logic               acc;
        logic               drop;
    } t_res;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] dt;
        logic [16:0] u;
        bit          typed;
        t_res        res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = 1'b0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_cmd = '0;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [31:0] i_pos_z = '0;
    logic [31:0]        i_tick_amount = '0;
    logic [16:0]        i_sample_fraction = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic [6:0]         o_points_held;
    logic               o_accepted;
    logic               o_dropped_oldest;

    trail_point_buffer_arc_sampler_core dut (.*);

    always #1 i_clk = ~i_clk;

    // model state of the point ring
    logic [31:0] ring_x [RING];
    logic [31:0] ring_y [RING];
    logic [31:0] ring_z [RING];
    logic [31:0] ring_age [RING];
    int          ring_oldest;
    int          ring_count;
    logic [31:0] cfg_min_seg;
    logic [31:0] cfg_life;

    t_res        pending_words[$];
    int          err_count = 0;
    int          idle_cycles = 0;
    bit          hold_req = 0;
    t_row        rows[$];

    function automatic int slot_at(int i);
        return (ring_oldest + i) % RING;
    endfunction

    function automatic longint unsigned mag64(longint d);
        return d < 0 ? longint'(-d) : longint'(d);
    endfunction

    // squared distance from stored point s to (bx, by, bz), 66 bits
    function automatic logic [65:0] dist_sq(int s, logic [31:0] bx, logic [31:0] by,
                                            logic [31:0] bz);
        logic [65:0] sum;
        logic [65:0] m;
        sum = '0;
        m = 66'(mag64(longint'($signed(bx)) - longint'($signed(ring_x[s]))));
        sum += m * m;
        m = 66'(mag64(longint'($signed(by)) - longint'($signed(ring_y[s]))));
        sum += m * m;
        m = 66'(mag64(longint'($signed(bz)) - longint'($signed(ring_z[s]))));
        sum += m * m;
        return sum;
    endfunction

    function automatic longint unsigned root66(logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] root;
        logic [67:0] trial;
        rem = '0;
        root = '0;
        for (int k = 32; k >= 0; k--) begin
            rem = (rem << 2) | 68'(v[2*k +: 2]);
            trial = (root << 2) | 68'd1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 68'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[63:0];
    endfunction

    function automatic longint unsigned seg_len(int sa, int sb);
        return root66(dist_sq(sa, ring_x[sb], ring_y[sb], ring_z[sb]));
    endfunction

    function automatic logic [31:0] interp(logic [31:0] a, logic [31:0] b,
                                           longint unsigned f);
        longint av;
        longint d;
        longint unsigned off;
        av = $signed(a);
        d = longint'($signed(b)) - av;
        off = (mag64(d) * f) >> 16;
        return d < 0 ? 32'(av - longint'(off)) : 32'(av + longint'(off));
    endfunction

    // advance the ring by one word and give its result
    function automatic t_res trail_step(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
                                        logic [31:0] pz, logic [31:0] dt, logic [16:0] u_in);
        t_res r;
        bit take;
        int s;
        int last;
        longint unsigned total;
        longint unsigned target;
        longint unsigned accum;
        longint unsigned len;
        longint unsigned f;
        longint unsigned u;
        logic [32:0] a;
        r = '{default: '0};
        u = 64'(u_in);
        if (cmd == CMD_ADD) begin
            take = 1;
            if (ring_count > 0)
                take = dist_sq(slot_at(ring_count - 1), px, py, pz) >=
                       66'(cfg_min_seg) * 66'(cfg_min_seg);
            if (take) begin
                if (ring_count >= RING) begin
                    s = ring_oldest;
                    ring_oldest = (ring_oldest + 1) % RING;
                    r.drop = 1'b1;
                end else begin
                    s = slot_at(ring_count);
                    ring_count++;
                end
                ring_x[s] = px;
                ring_y[s] = py;
                ring_z[s] = pz;
                ring_age[s] = '0;
                r.acc = 1'b1;
            end
        end else if (cmd == CMD_TICK) begin
            for (int i = 0; i < ring_count; i++) begin
                s = slot_at(i);
                a = {1'b0, ring_age[s]} + {1'b0, dt};
                ring_age[s] = a[32] ? 32'hFFFF_FFFF : a[31:0];
            end
            while (ring_count > 0 && ring_age[ring_oldest] > cfg_life) begin
                ring_oldest = (ring_oldest + 1) % RING;
                ring_count--;
            end
            r.acc = 1'b1;
        end else if (cmd == CMD_SAMPLE && ring_count > 0) begin
            last = slot_at(ring_count - 1);
            r.x = ring_x[last];
            r.y = ring_y[last];
            r.z = ring_z[last];
            r.acc = 1'b1;
            total = 0;
            accum = 0;
            for (int i = 1; i < ring_count; i++)
                total += seg_len(slot_at(i - 1), slot_at(i));
            if (total > 0) begin
                if (u > 65536) u = 65536;
                target = (total * u) >> 16;
                for (int i = 1; i < ring_count; i++) begin
                    len = seg_len(slot_at(i - 1), slot_at(i));
                    if (target <= accum + len) begin
                        f = len != 0 ? ((target - accum) << 16) / len : 0;
                        r.x = interp(ring_x[slot_at(i - 1)], ring_x[slot_at(i)], f);
                        r.y = interp(ring_y[slot_at(i - 1)], ring_y[slot_at(i)], f);
                        r.z = interp(ring_z[slot_at(i - 1)], ring_z[slot_at(i)], f);
                        break;
                    end
                    accum += len;
                end
            end
        end
        r.held = 7'(ring_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        err_count++;
    endtask

    task automatic enqueue_result(t_res r);
        pending_words = {pending_words, r};
    endtask

    task automatic add_row(t_row w);
        rows = {rows, w};
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_MIN_SEG) cfg_min_seg = data;
        else cfg_life = data;
    endtask

    // offer one word, hold it until taken, predict on acceptance
    task automatic send_word(t_row w);
        t_res p;
        i_valid           <= 1'b1;
        i_cmd             <= w.cmd;
        i_pos_x           <= w.x;
        i_pos_y           <= w.y;
        i_pos_z           <= w.z;
        i_tick_amount     <= w.dt;
        i_sample_fraction <= w.u;
        do @(posedge i_clk); while (!o_ready);
        p = trail_step(w.cmd, w.x, w.y, w.z, w.dt, w.u);
        enqueue_result(w.typed ? w.res : p);
    endtask

    task automatic gap_then(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic t_row mk(logic [1:0] cmd, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z, logic [31:0] dt, logic [16:0] u,
                                bit typed = 0, logic [31:0] ex = 0, logic [31:0] ey = 0,
                                logic [31:0] ez = 0, logic [6:0] held = 0,
                                logic acc = 0, logic drop = 0);
        t_row w;
        w.cmd = cmd; w.x = x; w.y = y; w.z = z; w.dt = dt; w.u = u;
        w.typed = typed;
        w.res = '{x: ex, y: ey, z: ez, held: held, acc: acc, drop: drop};
        return w;
    endfunction

    // receiver: random stalls, one long hold on request
    initial begin
        t_res want;
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (hold_req) begin
                stall = HOLD_LEN;
                hold_req = 0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word, points_held", 32'(o_points_held), 32'd0);
            end else begin
                want = pending_words.pop_front();
                if (o_out_x !== want.x) report_mismatch("out_x", o_out_x, want.x);
                if (o_out_y !== want.y) report_mismatch("out_y", o_out_y, want.y);
                if (o_out_z !== want.z) report_mismatch("out_z", o_out_z, want.z);
                if (o_points_held !== want.held)
                    report_mismatch("points_held", 32'(o_points_held), 32'(want.held));
                if (o_accepted !== want.acc)
                    report_mismatch("accepted", 32'(o_accepted), 32'(want.acc));
                if (o_dropped_oldest !== want.drop)
                    report_mismatch("dropped_oldest", 32'(o_dropped_oldest),
                                    32'(want.drop));
            end
        end
    end

    // watchdog on cycles without any input or output handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_MAX) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_row w;
        logic [31:0] lx, ly, lz;
        logic [31:0] mins [5];
        logic [31:0] lives [5];
        int sel;

        for (int i = 0; i < RING; i++) begin
            ring_x[i] = '0; ring_y[i] = '0; ring_z[i] = '0; ring_age[i] = '0;
        end
        ring_oldest = 0;
        ring_count  = 0;
        cfg_min_seg = 32'd0;
        cfg_life    = 32'd65536;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; typed rows read straight off the behaviour
        add_row(mk(CMD_SAMPLE, 0, 0, 0, 0, 17'h1FFFF, 1, 0, 0, 0, 0, 0, 0));
        add_row(mk(2'd3, '1, '1, '1, '1, '1, 1, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_TICK, 0, 0, 0, 5, 0, 1, 0, 0, 0, 0, 1, 0));
        add_row(mk(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0,
                   1, 0, 0, 0, 1, 1, 0));
        add_row(mk(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0,
                   1, 0, 0, 0, 2, 1, 0));
        add_row(mk(CMD_SAMPLE, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                   2, 1, 0));
        add_row(mk(CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
        add_row(mk(CMD_SAMPLE, 0, 0, 0, 0, 17'd65536));
        add_row(mk(CMD_SAMPLE, 0, 0, 0, 0, 17'h1FFFF));
        add_row(mk(CMD_SAMPLE, 0, 0, 0, 0, 17'd32768));
        add_row(mk(CMD_SAMPLE, 0, 0, 0, 0, 17'd0));
        add_row(mk(CMD_ADD, 0, 0, 0, 0, 0));
        add_row(mk(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0, 1, 0));
        add_row(mk(CMD_ADD, 1, 2, 3, 0, 0, 1, 0, 0, 0, 1, 1, 0));
        add_row(mk(CMD_SAMPLE, 0, 0, 0, 0, 17'd40000, 1, 1, 2, 3, 1, 1, 0));
        add_row(mk(CMD_TICK, 0, 0, 0, 32'h8000, 0, 1, 0, 0, 0, 1, 1, 0));
        add_row(mk(CMD_TICK, 0, 0, 0, 32'h8000, 0, 1, 0, 0, 0, 1, 1, 0));
        add_row(mk(CMD_TICK, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1, 0));
        // zero-length first segment hit by the target
        add_row(mk(CMD_ADD, 10, 10, 10, 0, 0));
        add_row(mk(CMD_ADD, 10, 10, 10, 0, 0));
        add_row(mk(CMD_ADD, 32'h10_0000, 0, 0, 0, 0));
        add_row(mk(CMD_SAMPLE, 0, 0, 0, 0, 17'd0));
        add_row(mk(CMD_SAMPLE, 0, 0, 0, 0, 17'd50000));
        foreach (rows[i]) begin
            send_word(rows[i]);
            gap_then($urandom_range(0, 2));
        end
        drain();

        // settings visited by the random phases
        mins[0] = 32'd0;          lives[0] = 32'd65536;
        mins[1] = 32'hFFFF_FFFF;  lives[1] = 32'hFFFF_FFFF;
        mins[2] = 32'd0;          lives[2] = 32'd0;
        mins[3] = $urandom_range(0, 1 << 19);
        lives[3] = $urandom_range(65536, 1 << 20);
        mins[4] = 32'd4096;       lives[4] = 32'hFFFF_FFFF;

        lx = 0; ly = 0; lz = 0;
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_MIN_SEG, mins[ph]);
            write_reg(CFG_LIFE, lives[ph]);
            for (int n = 0; n < PHASE_LEN; n++) begin
                w = mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                       17'($urandom_range(0, 17'h1FFFF)));
                sel = $urandom_range(0, 99);
                if (sel < 55) begin
                    w.cmd = CMD_ADD;
                    if ($urandom_range(0, 7) != 0) begin
                        w.x = lx + $urandom_range(0, 1 << 20) - (1 << 19);
                        w.y = ly + $urandom_range(0, 1 << 20) - (1 << 19);
                        w.z = lz + $urandom_range(0, 1 << 20) - (1 << 19);
                    end
                    lx = w.x; ly = w.y; lz = w.z;
                end else if (sel < 72) begin
                    w.cmd = CMD_TICK;
                    if ($urandom_range(0, 7) != 0) w.dt = $urandom_range(0, 32768);
                end else if (sel < 95) begin
                    w.cmd = CMD_SAMPLE;
                end else begin
                    w.cmd = 2'd3;
                end
                if (ph == 4 && n == 40) hold_req = 1;
                send_word(w);
                if ($urandom_range(0, 2) != 0) gap_then($urandom_range(0, 6));
            end
            drain();
        end

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
